[design/assert_macros.svh]
// Assertion helpers used by the checker file epdf_checker.
// Each macro expands to one labeled concurrent assertion with a reset guard.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[design/epdf_pkg.sv]
// ----------------------------------------------------------------------------
// epdf_pkg
// Types, register indexes and CRC-8 helper for the event packet deframer.
// ----------------------------------------------------------------------------
package epdf_pkg;

    localparam int BYTE_W    = 8;
    localparam int PKT_LEN   = 7;            // header1 header2 ver seq code crc tail
    localparam int WIN_KEEP  = PKT_LEN - 1;  // bytes held between beats
    localparam int FILL_W    = 3;
    localparam int CFG_IDX_W = 8;
    localparam int CRC_SPAN  = 3;

    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h07;

    // window slots
    localparam int SLOT_HDR1 = 0;
    localparam int SLOT_HDR2 = 1;
    localparam int SLOT_VER  = 2;
    localparam int SLOT_SEQ  = 3;
    localparam int SLOT_CODE = 4;
    localparam int SLOT_CRC  = 5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_FIRST  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_SECOND = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VERSION_BYTE  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TAIL_BYTE     = 8'd3;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [WIN_KEEP-1:0][BYTE_W-1:0] t_win;
    typedef logic [FILL_W-1:0] t_fill;

    typedef struct packed {
        t_byte header_first;
        t_byte header_second;
        t_byte version_byte;
        t_byte tail_byte;
    } t_cfg;

    typedef struct packed {
        logic  pass;
        t_byte event_code;
        t_byte sequence_number;
    } t_check;

    // One byte through the MSB-first CRC-8 register; linear, so it maps to XOR trees.
    function automatic t_byte crc8_byte(input t_byte acc_in, input t_byte data);
        t_byte acc;
        acc = acc_in ^ data;
        for (int b = 0; b < BYTE_W; b++) begin
            if (acc[BYTE_W-1]) begin
                acc = {acc[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                acc = {acc[BYTE_W-2:0], 1'b0};
            end
        end
        return acc;
    endfunction

endpackage

[design/epdf_check.sv]
// ----------------------------------------------------------------------------
// epdf_check
// Frame check of a full seven-byte window: headers, version, tail and CRC-8.
// ----------------------------------------------------------------------------
module epdf_check import epdf_pkg::*; (
    input  t_cfg   i_cfg,
    input  t_win   i_win,      // six held bytes, oldest in slot 0
    input  t_byte  i_tail,     // byte arriving now, seventh of the frame
    output t_check o_check
);

    t_byte crc;

    always_comb begin
        crc = '0;
        for (int i = 0; i < CRC_SPAN; i++) begin
            crc = crc8_byte(crc, i_win[SLOT_VER + i]);
        end
    end

    assign o_check.pass = (i_win[SLOT_HDR1] == i_cfg.header_first)
                       && (i_win[SLOT_HDR2] == i_cfg.header_second)
                       && (i_win[SLOT_VER]  == i_cfg.version_byte)
                       && (i_tail           == i_cfg.tail_byte)
                       && (i_win[SLOT_CRC]  == crc);
    assign o_check.event_code      = i_win[SLOT_CODE];
    assign o_check.sequence_number = i_win[SLOT_SEQ];

endmodule

[design/event_packet_deframer_crc8_unit.sv]
// ----------------------------------------------------------------------------
// event_packet_deframer_crc8_unit
// Receives serial bytes and emits code and sequence of each valid packet.
// ----------------------------------------------------------------------------
// Takes one received byte per beat and hunts for the seven-byte frame
// header1, header2, version, seq, code, crc, tail. Six bytes are held in a
// shift window with a fill count; when the seventh arrives the frame is
// checked against the four configuration registers and a CRC-8 (poly 0x07,
// init 0, MSB first, no final xor) over version, seq and code. A good frame
// yields one result beat {event_code, sequence_number} and empties the
// window; a bad one drops the oldest byte and the hunt goes on one byte
// later. Throughput is one input beat per clock while o_stall is low: the
// window update and the frame check are a single register-to-register
// pass. Results go through a two-entry output buffer: a result is
// registered in the output register, or in the skid slot while a stalled
// result holds that register; o_stall rises only while the skid slot is
// occupied, i.e. after the consumer stalled a result and another one
// arrived behind it. Configuration writes are always ready and must land
// while no frame is in flight; indexes above the tail register are ignored.
module event_packet_deframer_crc8_unit import epdf_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input byte stream
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [7:0]           i_rx_byte,
    // result stream
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [7:0]           o_event_code,
    output logic [7:0]           o_sequence_number,
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_HEADER_FIRST:  r_cfg.header_first  <= i_cfg_data;
                REG_HEADER_SECOND: r_cfg.header_second <= i_cfg_data;
                REG_VERSION_BYTE:  r_cfg.version_byte  <= i_cfg_data;
                REG_TAIL_BYTE:     r_cfg.tail_byte     <= i_cfg_data;
                default: ;         // unmapped index, write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // byte window
    // ------------------------------------------------------------------
    t_win   r_win;
    t_fill  r_fill;
    t_check frame;
    logic   in_beat;
    logic   win_full;
    logic   hit;

    assign in_beat  = i_valid && !o_stall;
    assign win_full = (r_fill == t_fill'(WIN_KEEP));
    assign hit      = in_beat && win_full && frame.pass;

    epdf_check u_check (
        .i_cfg   (r_cfg),
        .i_win   (r_win),
        .i_tail  (i_rx_byte),
        .o_check (frame)
    );

    // fill count: counts up to six, then either empties on a good frame or
    // stays at six while the window slides
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (in_beat) begin
            if (!win_full) begin
                r_fill <= r_fill + t_fill'(1);
            end else if (frame.pass) begin
                r_fill <= '0;
            end
        end
    end

    // window payload, no reset: slots at or above the fill count are never read
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            if (!win_full) begin
                r_win[r_fill] <= i_rx_byte;
            end else if (!frame.pass) begin
                for (int i = 0; i < WIN_KEEP - 1; i++) begin
                    r_win[i] <= r_win[i+1];
                end
                r_win[WIN_KEEP-1] <= i_rx_byte;
            end
        end
    end

    // ------------------------------------------------------------------
    // output register with skid slot
    // ------------------------------------------------------------------
    logic  r_out_valid;
    t_byte r_out_code;
    t_byte r_out_seq;
    logic  r_skid_valid;
    t_byte r_skid_code;
    t_byte r_skid_seq;
    logic  out_free;

    assign out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            // skid slot full means input was stalled, so no new hit here
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= hit;
            end
        end else if (hit) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out_code <= r_skid_code;
                r_out_seq  <= r_skid_seq;
            end else if (hit) begin
                r_out_code <= frame.event_code;
                r_out_seq  <= frame.sequence_number;
            end
        end else if (hit) begin
            r_skid_code <= frame.event_code;
            r_skid_seq  <= frame.sequence_number;
        end
    end

    assign o_stall           = r_skid_valid;
    assign o_valid           = r_out_valid;
    assign o_event_code      = r_out_code;
    assign o_sequence_number = r_out_seq;

endmodule

[design/epdf_checker.sv]
// ----------------------------------------------------------------------------
// epdf_checker
// Port-level checks of the event packet deframer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module epdf_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 o_stall,
    input logic                 o_valid,
    input logic                 i_stall,
    input logic [7:0]           o_event_code,
    input logic [7:0]           o_sequence_number
);

    // stalled result beat stays up
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid)

    // stalled result beat keeps its payload
    `ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_valid && i_stall,
        $stable(o_event_code) && $stable(o_sequence_number))

    // a fresh result only follows a taken input byte
    `ASSERT_IMPL(a_out_cause, i_clk, i_rst_n, $rose(o_valid), $past(i_valid && !o_stall))

    // input backpressure only after a result was held back
    `ASSERT_IMPL(a_stall_cause, i_clk, i_rst_n, o_stall, $past(o_valid && i_stall))

endmodule

bind event_packet_deframer_crc8_unit epdf_checker u_epdf_checker (.*);
